>>> src/srwv_pkg.sv
// Shared package of the strided row window variance block.
// Field widths, request and register codes, and default sizes.
// No dependencies; every other file of the block uses it.
package srwv_pkg;

    localparam int ROW_FIELD_W = 7;
    localparam int SLOPE_W = 16;
    localparam int VAR_W = 31;
    localparam int COUNT_W = 7;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam int ROW_COUNT_DEF = 128;
    localparam int ROW_STRIDE = 2;

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_VALID_ROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_ENABLE = 1'b1;

endpackage

>>> src/srwv_if.sv
// Request and result channels of the strided row window variance block.
// Valid/ready handshake with the payload fields; depends on srwv_pkg.
interface srwv_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 req_type;
    logic [srwv_pkg::ROW_FIELD_W-1:0]     row_start;
    logic [srwv_pkg::ROW_FIELD_W-1:0]     row_end;
    logic signed [srwv_pkg::SLOPE_W-1:0]  slope;

    modport source (output valid, req_type, row_start, row_end, slope, input ready);
    modport sink (input valid, req_type, row_start, row_end, slope, output ready);
endinterface

interface srwv_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [srwv_pkg::VAR_W-1:0]       variance;
    logic [srwv_pkg::COUNT_W-1:0]     sample_count;
    logic                             window_empty;

    modport source (output valid, variance, sample_count, window_empty, input ready);
    modport sink (input valid, variance, sample_count, window_empty, output ready);
endinterface

>>> src/srwv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the slope table; depends on srwv_pkg for default sizes.
module srwv_ram #(
    parameter int WIDTH = srwv_pkg::SLOPE_W,
    parameter int DEPTH = srwv_pkg::ROW_COUNT_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/strided_row_window_variance_top.sv
// Channel  Direction  Handshake      Word
// req      in         valid/ready    req_type, row_start, row_end, slope
// rsp      out        valid/ready    variance, sample_count, window_empty
// cfg      in         cfg_we         cfg_index, cfg_data
//
// A query spends a check step on the table read port and a sample step on each
// visited row, then 45 steps in the bit-serial divider. Reset clears the
// sequencer, the result valid flag and the lowest valid row and sets clamping
// on; the datapath registers and the slope table are not cleared. A stalled
// result waits in the output register while the next request is already taken.
// Top level of the block; depends on srwv_pkg, srwv_if and srwv_ram.
module strided_row_window_variance_top #(
    parameter int ROW_COUNT = srwv_pkg::ROW_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    srwv_req_if.sink                          req,
    srwv_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [srwv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srwv_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(ROW_COUNT);
    localparam int RF_W = srwv_pkg::ROW_FIELD_W;
    localparam int ROW_W = RF_W + 2;
    localparam int N_W = srwv_pkg::COUNT_W;
    localparam int S_W = srwv_pkg::SLOPE_W;
    localparam int SUM_W = S_W + N_W;
    localparam int SQ_W = 2 * S_W - 1;
    localparam int SUMSQ_W = SQ_W + N_W;
    localparam int T1_W = N_W + SUMSQ_W;
    localparam int T2_W = 2 * SUM_W;
    localparam int DEN_W = 2 * N_W;
    localparam int DIV_CNT_W = $clog2(T1_W + 1);
    localparam int V_W = srwv_pkg::VAR_W;

    typedef logic [3:0] pc_t;

    localparam pc_t PC_IDLE = 4'd0;
    localparam pc_t PC_CHECK = 4'd1;
    localparam pc_t PC_SAMPLE = 4'd2;
    localparam pc_t PC_NZ = 4'd3;
    localparam pc_t PC_MUL_T1 = 4'd4;
    localparam pc_t PC_MUL_T2 = 4'd5;
    localparam pc_t PC_MUL_DEN = 4'd6;
    localparam pc_t PC_DIV = 4'd7;
    localparam pc_t PC_PUT = 4'd8;
    localparam pc_t PC_LAST = PC_PUT;

    typedef enum logic [2:0] {
        CND_NEXT,
        CND_ALWAYS,
        CND_NO_QUERY,
        CND_WIN_DONE,
        CND_N_ZERO,
        CND_DIV_LEFT,
        CND_OUT_FULL
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  rd_row;
        logic  acc_sq;
        logic  sample;
        logic  mul_t1;
        logic  mul_t2;
        logic  mul_den;
        logic  div_step;
        logic  put;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    // Microcode: each step names its datapath actions, a jump condition and a target.
    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t c;
        c = '0;
        c.cond = CND_NEXT;
        c.target = PC_IDLE;
        case (pc)
            PC_IDLE:
            begin
                c.take_in = 1'b1;
                c.cond = CND_NO_QUERY;
                c.target = PC_IDLE;
            end
            PC_CHECK:
            begin
                c.rd_row = 1'b1;
                c.acc_sq = 1'b1;
                c.cond = CND_WIN_DONE;
                c.target = PC_NZ;
            end
            PC_SAMPLE:
            begin
                c.sample = 1'b1;
                c.cond = CND_ALWAYS;
                c.target = PC_CHECK;
            end
            PC_NZ:
            begin
                c.cond = CND_N_ZERO;
                c.target = PC_PUT;
            end
            PC_MUL_T1:
            begin
                c.mul_t1 = 1'b1;
            end
            PC_MUL_T2:
            begin
                c.mul_t2 = 1'b1;
            end
            PC_MUL_DEN:
            begin
                c.mul_den = 1'b1;
            end
            PC_DIV:
            begin
                c.div_step = 1'b1;
                c.cond = CND_DIV_LEFT;
                c.target = PC_DIV;
            end
            PC_PUT:
            begin
                c.put = 1'b1;
                c.cond = CND_OUT_FULL;
                c.target = PC_PUT;
            end
            default:
            begin
                c.cond = CND_ALWAYS;
                c.target = PC_IDLE;
            end
        endcase
        return c;
    endfunction

    ctrl_t ctrl;
    logic  jump;
    logic  out_full;
    logic  req_fire;
    logic  ram_we;
    logic  row_ok;
    logic [S_W-1:0] ram_rdata;

    logic signed [S_W-1:0]  v;
    logic signed [2*S_W-1:0] sq_full;
    logic [SUM_W-1:0]       asum;
    logic [RF_W:0]          lvr_p1;
    logic [RF_W:0]          end_clamped;
    logic [DEN_W:0]         trial;

    pc_t pc_reg, pc_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic [RF_W-1:0] lvr_reg, lvr_next;
    logic clamp_reg, clamp_next;

    logic signed [ROW_W-1:0] row_reg, row_next;
    logic signed [ROW_W-1:0] end_reg, end_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [SUMSQ_W-1:0]      sumsq_reg, sumsq_next;
    logic [N_W-1:0]          n_reg, n_next;
    logic [T1_W-1:0]         t1_reg, t1_next;
    logic [T2_W-1:0]         t2_reg, t2_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [T1_W-1:0]         quo_reg, quo_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [V_W-1:0]          var_reg, var_next;
    logic [N_W-1:0]          cnt_out_reg, cnt_out_next;
    logic                    empty_reg, empty_next;

    assign ctrl = ucode(pc_reg);
    assign req.ready = ctrl.take_in;
    assign req_fire = ctrl.take_in && req.valid;
    assign out_full = rsp_valid_reg && !rsp.ready;

    assign ram_we = req_fire && (req.req_type == srwv_pkg::REQ_STORE)
                    && (32'(req.row_start) < ROW_COUNT);
    assign row_ok = 32'(row_reg[RF_W-1:0]) < ROW_COUNT;

    srwv_ram #(
        .WIDTH (S_W),
        .DEPTH (ROW_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(req.row_start)),
        .wdata (req.slope),
        .re    (ctrl.rd_row),
        .raddr (AW'(row_reg[RF_W-1:0])),
        .rdata (ram_rdata)
    );

    assign v = row_ok ? $signed(ram_rdata) : '0;
    assign sq_full = v * v;
    assign asum = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign lvr_p1 = {1'b0, lvr_reg} + {{RF_W{1'b0}}, 1'b1};
    assign end_clamped = (clamp_reg && ({1'b0, req.row_end} <= lvr_p1))
                         ? lvr_p1 : {1'b0, req.row_end};
    assign trial = {rem_reg, quo_reg[T1_W-1]};

    always_comb
    begin
        case (ctrl.cond)
            CND_NEXT:     jump = 1'b0;
            CND_ALWAYS:   jump = 1'b1;
            CND_NO_QUERY: jump = !(req.valid && (req.req_type == srwv_pkg::REQ_QUERY));
            CND_WIN_DONE: jump = !(row_reg > end_reg);
            CND_N_ZERO:   jump = (n_reg == '0);
            CND_DIV_LEFT: jump = (cnt_reg != DIV_CNT_W'(1));
            CND_OUT_FULL: jump = out_full;
            default:      jump = 1'b0;
        endcase
        if (jump)
        begin
            pc_next = ctrl.target;
        end
        else if (pc_reg == PC_LAST)
        begin
            pc_next = PC_IDLE;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    always_comb
    begin
        lvr_next = lvr_reg;
        clamp_next = clamp_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                srwv_pkg::CFG_LOWEST_VALID_ROW: lvr_next = cfg_data[RF_W-1:0];
                srwv_pkg::CFG_CLAMP_ENABLE:     clamp_next = cfg_data[0];
                default:                        lvr_next = lvr_reg;
            endcase
        end
    end

    always_comb
    begin
        row_next = row_reg;
        end_next = end_reg;
        sum_next = sum_reg;
        sq_next = sq_reg;
        sumsq_next = sumsq_reg;
        n_next = n_reg;
        t1_next = t1_reg;
        t2_next = t2_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        var_next = var_reg;
        cnt_out_next = cnt_out_reg;
        empty_next = empty_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (req_fire && (req.req_type == srwv_pkg::REQ_QUERY))
        begin
            row_next = $signed(ROW_W'(req.row_start));
            end_next = $signed(ROW_W'(end_clamped));
            sum_next = '0;
            sq_next = '0;
            sumsq_next = '0;
            n_next = '0;
        end
        if (ctrl.acc_sq)
        begin
            sumsq_next = sumsq_reg + SUMSQ_W'(sq_reg);
        end
        if (ctrl.sample)
        begin
            sq_next = sq_full[SQ_W-1:0];
            sum_next = sum_reg + SUM_W'(v);
            n_next = n_reg + N_W'(1);
            row_next = row_reg - ROW_W'(srwv_pkg::ROW_STRIDE);
        end
        if (ctrl.mul_t1)
        begin
            t1_next = T1_W'(n_reg) * T1_W'(sumsq_reg);
        end
        if (ctrl.mul_t2)
        begin
            t2_next = T2_W'(asum) * T2_W'(asum);
        end
        if (ctrl.mul_den)
        begin
            den_next = DEN_W'(n_reg) * DEN_W'(n_reg);
            quo_next = t1_reg - t2_reg[T1_W-1:0];
            rem_next = '0;
            cnt_next = DIV_CNT_W'(T1_W);
        end
        if (ctrl.div_step)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[T1_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[T1_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
        end
        if (ctrl.put && !out_full)
        begin
            rsp_valid_next = 1'b1;
            cnt_out_next = n_reg;
            empty_next = (n_reg == '0);
            var_next = (n_reg == '0) ? '0 : quo_reg[V_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
            rsp_valid_reg <= 1'b0;
            lvr_reg <= '0;
            clamp_reg <= 1'b1;
        end
        else
        begin
            pc_reg <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
            lvr_reg <= lvr_next;
            clamp_reg <= clamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        end_reg <= end_next;
        sum_reg <= sum_next;
        sq_reg <= sq_next;
        sumsq_reg <= sumsq_next;
        n_reg <= n_next;
        t1_reg <= t1_next;
        t2_reg <= t2_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        var_reg <= var_next;
        cnt_out_reg <= cnt_out_next;
        empty_reg <= empty_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.variance = var_reg;
    assign rsp.sample_count = cnt_out_reg;
    assign rsp.window_empty = empty_reg;

endmodule
